// ===== src/slcfp_pkg.sv =====
// Shared types and constants of the sync/length/checksum frame parser.
`default_nettype none

package slcfp_pkg;

    // Parser phase codes (front end)
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;

    // Beat classes handed from the front end to the back end
    localparam logic [2:0] K_LEN_HI = 3'd0;
    localparam logic [2:0] K_LEN_LO = 3'd1;
    localparam logic [2:0] K_ZERO   = 3'd2;
    localparam logic [2:0] K_FIRST  = 3'd3;
    localparam logic [2:0] K_ADDR   = 3'd4;
    localparam logic [2:0] K_BODY   = 3'd5;
    localparam logic [2:0] K_CHECK  = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SYNC   = 1'b0;
    localparam logic CFG_REPORT = 1'b1;

    localparam logic [7:0] SYNC_RESET   = 8'hAA;
    localparam logic [7:0] REPORT_RESET = 8'h70;

    // First and last body byte that lands in the address
    localparam logic [15:0] ADDR_FIRST = 16'd3;
    localparam logic [15:0] ADDR_LAST  = 16'd8;
    localparam logic [15:0] ADDR_MIN_LEN = 16'd9;

    // Queue between front and back end
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  opcode;
        logic [15:0] body_length;
        logic [7:0]  received_checksum;
        logic [7:0]  computed_checksum;
        logic [47:0] device_address;
        logic        address_valid;
    } t_result;

endpackage

`default_nettype wire

// ===== src/slcfp_in_if.sv =====
// Input byte channel: valid/ready handshake with one received byte.
`default_nettype none

interface slcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/slcfp_out_if.sv =====
// Result channel: valid/ready handshake with one frame report.
`default_nettype none

interface slcfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  opcode;
    logic [15:0] body_length;
    logic [7:0]  received_checksum;
    logic [7:0]  computed_checksum;
    logic [47:0] device_address;
    logic        address_valid;

    modport source (output valid, output status, output opcode, output body_length,
                    output received_checksum, output computed_checksum,
                    output device_address, output address_valid, input ready);
    modport sink   (input valid, input status, input opcode, input body_length,
                    input received_checksum, input computed_checksum,
                    input device_address, input address_valid, output ready);
endinterface

`default_nettype wire

// ===== src/sync_length_checksum_frame_parser.sv =====
// Top level of the sync/length/checksum frame parser.
//
//   channel  dir  handshake         payload
//   in_ch    in   valid/ready       data_byte[7:0]
//   out_ch   out  valid/ready       status, opcode, body_length, received_checksum,
//                                   computed_checksum, device_address, address_valid
//   cfg      in   i_cfg_we          i_cfg_idx (0 sync_byte, 1 report_opcode), i_cfg_data
//
// One byte is taken every cycle while the four-beat queue has room; the front end
// classifies it in the cycle it arrives and the back end retires one beat a cycle
// unless a report beat waits on a full result slot. A taken checksum or length byte
// passes the queue, then the result register, later behind queued beats or a stall.
// Reset clears phase, queue and result valid; config returns to 0xAA and 0x70.
// An output stall stops only report beats in the back end; bytes keep flowing
// into the queue until it fills, then in_ch.ready drops.
`default_nettype none

module sync_length_checksum_frame_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    slcfp_in_if.sink        in_ch,
    slcfp_out_if.source     out_ch,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);
    import slcfp_pkg::*;

    logic [7:0] r_sync_byte;
    logic [7:0] r_report_opcode;
    logic       push, pop, q_full, q_valid;
    t_beat      front_beat, q_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte     <= SYNC_RESET;
            r_report_opcode <= REPORT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC:   r_sync_byte     <= i_cfg_data;
                CFG_REPORT: r_report_opcode <= i_cfg_data;
                default:    r_sync_byte     <= r_sync_byte;
            endcase
        end
    end

    slcfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .i_sync_byte (r_sync_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_beat      (front_beat)
    );

    slcfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (front_beat),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_beat  (q_beat)
    );

    slcfp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_beat          (q_beat),
        .i_report_opcode (r_report_opcode),
        .o_pop           (pop),
        .out_ch          (out_ch)
    );

endmodule

`default_nettype wire

// ===== src/slcfp_front.sv =====
// Front end: hunts for sync, tracks frame position and classifies each frame byte.
`default_nettype none

module slcfp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    slcfp_in_if.sink           in_ch,
    input  wire logic [7:0]    i_sync_byte,
    input  wire logic          i_q_full,
    output logic               o_push,
    output slcfp_pkg::t_beat   o_beat
);
    import slcfp_pkg::*;

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_count, n_count;
    logic [15:0] count_inc;
    logic [15:0] len_full;
    logic        accept;

    assign in_ch.ready = !i_q_full;
    assign accept      = in_ch.valid && !i_q_full;
    assign count_inc   = r_count + 16'd1;
    assign len_full    = {r_len[15:8], in_ch.data_byte};

    always_comb begin
        n_phase     = r_phase;
        n_len       = r_len;
        n_count     = r_count;
        o_push      = 1'b0;
        o_beat.data = in_ch.data_byte;
        o_beat.kind = K_BODY;
        if (accept) begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    o_push      = 1'b1;
                    o_beat.kind = K_LEN_HI;
                    n_len       = {in_ch.data_byte, 8'h00};
                    n_phase     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    o_push  = 1'b1;
                    n_len   = len_full;
                    n_count = '0;
                    if (len_full == '0) begin
                        o_beat.kind = K_ZERO;
                        n_phase     = PH_HUNT;
                    end else begin
                        o_beat.kind = K_LEN_LO;
                        n_phase     = PH_BODY;
                    end
                end
                PH_BODY: begin
                    o_push = 1'b1;
                    if (r_count == '0) begin
                        o_beat.kind = K_FIRST;
                    end else if (r_count >= ADDR_FIRST && r_count <= ADDR_LAST) begin
                        o_beat.kind = K_ADDR;
                    end else begin
                        o_beat.kind = K_BODY;
                    end
                    n_count = count_inc;
                    if (count_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_push      = 1'b1;
                    o_beat.kind = K_CHECK;
                    n_phase     = PH_HUNT;
                end
                default: begin
                    // hunt; unused codes fall back here too
                    n_phase = (in_ch.data_byte == i_sync_byte) ? PH_LEN_HI : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== src/slcfp_queue.sv =====
// Short beat queue between front and back end.
`default_nettype none

module slcfp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire slcfp_pkg::t_beat   i_beat,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_valid,
    output slcfp_pkg::t_beat        o_beat
);
    import slcfp_pkg::*;

    t_beat          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_beat  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/slcfp_back.sv =====
// Back end: checksum, opcode and address tracking, result register.
`default_nettype none

module slcfp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire slcfp_pkg::t_beat   i_beat,
    input  wire logic [7:0]         i_report_opcode,
    output logic                    o_pop,
    slcfp_out_if.source             out_ch
);
    import slcfp_pkg::*;

    logic [15:0] r_len, n_len;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_op, n_op;
    logic [47:0] r_addr, n_addr;
    logic        r_out_valid;
    t_result     r_out, n_out;
    logic        has_result, slot_free, load;
    logic [7:0]  calc;
    logic        addr_ok;

    assign has_result = (i_beat.kind == K_ZERO) || (i_beat.kind == K_CHECK);
    assign slot_free  = !r_out_valid || out_ch.ready;
    assign o_pop      = i_q_valid && (!has_result || slot_free);
    assign load       = o_pop && has_result;
    assign calc       = 8'd0 - r_sum;
    assign addr_ok    = (r_op == i_report_opcode) && (r_len >= ADDR_MIN_LEN);

    always_comb begin
        n_len = r_len;
        n_sum = r_sum;
        n_op  = r_op;
        n_addr = r_addr;
        n_out = '0;
        n_out.status = ST_ZERO;
        unique case (i_beat.kind)
            K_LEN_HI: begin
                n_len = {i_beat.data, 8'h00};
                n_sum = i_beat.data;
            end
            K_LEN_LO: begin
                n_len  = {r_len[15:8], i_beat.data};
                n_sum  = r_sum + i_beat.data;
                n_op   = '0;
                n_addr = '0;
            end
            K_ZERO: begin
                n_len  = '0;
                n_op   = '0;
                n_addr = '0;
            end
            K_FIRST: begin
                n_sum = r_sum + i_beat.data;
                n_op  = i_beat.data;
            end
            K_ADDR: begin
                n_sum  = r_sum + i_beat.data;
                n_addr = {r_addr[39:0], i_beat.data};
            end
            K_CHECK: begin
                n_out.status            = (calc == i_beat.data) ? ST_GOOD : ST_BAD;
                n_out.opcode            = r_op;
                n_out.body_length       = r_len;
                n_out.received_checksum = i_beat.data;
                n_out.computed_checksum = calc;
                n_out.device_address    = addr_ok ? r_addr : '0;
                n_out.address_valid     = addr_ok;
            end
            default: begin
                n_sum = r_sum + i_beat.data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_sum       <= '0;
            r_op        <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_len  <= n_len;
                r_sum  <= n_sum;
                r_op   <= n_op;
                r_addr <= n_addr;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign out_ch.valid             = r_out_valid;
    assign out_ch.status            = r_out.status;
    assign out_ch.opcode            = r_out.opcode;
    assign out_ch.body_length       = r_out.body_length;
    assign out_ch.received_checksum = r_out.received_checksum;
    assign out_ch.computed_checksum = r_out.computed_checksum;
    assign out_ch.device_address    = r_out.device_address;
    assign out_ch.address_valid     = r_out.address_valid;

    // A result beat only leaves the queue when the output slot can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !out_ch.ready) |-> !load)
        else $error("result register overwritten while stalled");

    // A zero-length report carries no frame contents
    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && out_ch.status == ST_ZERO) |->
            (out_ch.opcode == '0 && out_ch.body_length == '0 &&
             !out_ch.address_valid && out_ch.computed_checksum == '0))
        else $error("zero-length report has nonzero fields");

    // Address bits stay clear unless the address is flagged
    a_addr_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !out_ch.address_valid) |-> (out_ch.device_address == '0))
        else $error("device address leaks without address_valid");

    // Status agrees with the checksum compare
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && out_ch.status != ST_ZERO) |->
            ((out_ch.status == ST_GOOD) ==
             (out_ch.received_checksum == out_ch.computed_checksum)))
        else $error("status disagrees with checksum compare");

endmodule

`default_nettype wire
